>>> hw/rtl/tama_pkg.sv
// Shared types and constants for the two-axis moving average block.
package tama_pkg;

  // Default ring depth and the stored delta width
  localparam int unsigned RING_DEPTH_DEFAULT = 8;
  localparam int unsigned DELTA_W            = 16;
  localparam int unsigned VALUE_W            = 32;
  localparam int unsigned WINDOW_W           = 4;

  // Window register value after reset
  localparam logic [WINDOW_W-1:0] WINDOW_RESET = 4'd3;

  // Event classes
  localparam logic [1:0] CLASS_X     = 2'd0;
  localparam logic [1:0] CLASS_Y     = 2'd1;
  localparam logic [1:0] CLASS_OTHER = 2'd2;

  // Input word
  typedef struct packed {
    logic [1:0]                event_class;
    logic signed [VALUE_W-1:0] sample_value;
    logic                      report_end;
  } in_word_t;

  // Output word
  typedef struct packed {
    logic signed [VALUE_W-1:0] result_value;
    logic                      was_smoothed;
  } out_word_t;

  // Divider handshake status
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

>>> hw/rtl/tama_div.sv
// Bit-serial signed divider of a window sum by an unsigned sample count.
module tama_div #(
  parameter int unsigned SumW = 19,
  parameter int unsigned CntW = 4
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic signed [SumW-1:0]              dividend_i,
  input  logic [CntW-1:0]                     divisor_i,
  output tama_pkg::div_status_t               status_o,
  output logic signed [tama_pkg::DELTA_W-1:0] quotient_o
);
  import tama_pkg::*;

  localparam int unsigned StepW = $clog2(SumW + 1);

  logic            busy_q;
  logic            done_q;
  logic            neg_q;
  logic [StepW-1:0] step_q;
  logic [SumW-1:0] quo_q;
  logic [CntW-1:0] rem_q;
  logic [CntW-1:0] dsr_q;
  logic [CntW:0]   rem_sh;
  logic            fits;
  logic [CntW:0]   rem_sub;
  logic [SumW-1:0] quo_signed;

  // One restoring step: shift in the next dividend bit, try the subtract
  always_comb begin
    rem_sh  = {rem_q, quo_q[SumW-1]};
    fits    = rem_sh >= {1'b0, dsr_q};
    rem_sub = rem_sh - {1'b0, dsr_q};
  end

  // Load on start, then iterate one quotient bit per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        if (step_q == StepW'(SumW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
        step_q <= step_q + 1'b1;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= dividend_i[SumW-1];
      quo_q <= dividend_i[SumW-1] ? SumW'(-dividend_i) : SumW'(dividend_i);
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? rem_sub[CntW-1:0] : rem_sh[CntW-1:0];
      quo_q <= {quo_q[SumW-2:0], fits};
    end
  end

  // Restore the sign and keep the low delta bits
  assign quo_signed      = neg_q ? (~quo_q + 1'b1) : quo_q;
  assign quotient_o      = quo_signed[DELTA_W-1:0];
  assign status_o.busy   = busy_q;
  assign status_o.done   = done_q;

endmodule

>>> hw/rtl/two_axis_moving_average.sv
// Top level of the two-axis moving average for relative pointer motion.
//
// Usage: input words (event class, value, report end) arrive on a valid/ready
// channel; each accepted word yields exactly one output word on a second
// valid/ready channel. X and Y deltas are stored, 16 bits wide, in two rings
// that share one write slot, and are replaced by the truncating mean of the
// newest samples of that axis. Other events, and every event while the window
// register is 0 or 1, pass through unchanged with was_smoothed low.
// The user must write the window register through cfg_we_i / cfg_wdata_i
// only while idle; the block does not enforce it. Timing: one word at a time.
// A passthrough word goes straight to the push state and enters the output
// register when that is free. A smoothed word takes n accumulate steps (n is
// the number of samples averaged, one step each through the shared adder), a
// divider start and SUM_W = 16 + log2(RingDepth) divider steps (19 at the
// default depth of 8). Input is ready again as a word enters the output register.
// Reset clears both rings, the write slot, the fill count and the seen flags,
// and sets the window to 3. When the receiver stalls, the finished word waits
// in the output register; the next input word is still taken and processed,
// and its result waits until the output register frees up.
module two_axis_moving_average #(
  parameter int unsigned RingDepth = tama_pkg::RING_DEPTH_DEFAULT
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  tama_pkg::in_word_t                in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output tama_pkg::out_word_t               out_data_o,
  input  logic                              cfg_we_i,
  input  logic [tama_pkg::WINDOW_W-1:0]     cfg_wdata_i
);
  import tama_pkg::*;

  localparam int unsigned IdxW = $clog2(RingDepth);
  localparam int unsigned CntW = $clog2(RingDepth + 1);
  localparam int unsigned SumW = DELTA_W + $clog2(RingDepth);
  localparam int unsigned CmpW = (CntW > WINDOW_W) ? CntW : WINDOW_W;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SUM   = 5'b00010,
    S_START = 5'b00100,
    S_DIV   = 5'b01000,
    S_PUSH  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic [WINDOW_W-1:0]        window_q;
  logic signed [DELTA_W-1:0]  x_ring_q [RingDepth];
  logic signed [DELTA_W-1:0]  y_ring_q [RingDepth];
  logic [IdxW-1:0]            slot_q;
  logic [CntW-1:0]            fill_q;
  logic                       x_seen_q;
  logic                       y_seen_q;

  logic                       axis_y_q;
  logic [IdxW-1:0]            rd_idx_q;
  logic [CntW-1:0]            left_q;
  logic [CntW-1:0]            cnt_q;
  logic signed [SumW-1:0]     acc_q;
  out_word_t                  res_q;
  out_word_t                  out_q;
  logic                       out_valid_q;

  logic                       accept;
  logic                       is_delta;
  logic                       win_pass;
  logic                       smooth;
  logic                       is_y;
  logic [CmpW-1:0]            win_ext;
  logic [CmpW-1:0]            depth_ext;
  logic [CntW-1:0]            win_eff;
  logic [CntW:0]              fill_inc;
  logic [CntW-1:0]            n_take;
  logic signed [DELTA_W-1:0]  delta;
  logic signed [DELTA_W-1:0]  rd_data;
  logic                       push;
  logic                       div_start;
  div_status_t                div_status;
  logic signed [DELTA_W-1:0]  div_quot;

  // Decode the word and clamp the window to at most RingDepth
  always_comb begin
    is_delta  = (in_data_i.event_class == CLASS_X) || (in_data_i.event_class == CLASS_Y);
    is_y      = (in_data_i.event_class == CLASS_Y);
    win_ext   = CmpW'(window_q);
    depth_ext = CmpW'(RingDepth);
    win_pass  = win_ext <= CmpW'(1);
    win_eff   = (win_ext > depth_ext) ? CntW'(RingDepth) : win_ext[CntW-1:0];
    smooth    = is_delta && !win_pass;
    fill_inc  = {1'b0, fill_q} + 1'b1;
    n_take    = (fill_inc > {1'b0, win_eff}) ? win_eff : fill_inc[CntW-1:0];
    delta     = in_data_i.sample_value[DELTA_W-1:0];
  end

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign rd_data    = axis_y_q ? y_ring_q[rd_idx_q] : x_ring_q[rd_idx_q];
  assign push       = (state_q == S_PUSH) && (!out_valid_q || out_ready_i);
  assign div_start  = (state_q == S_START);

  // Sequence: accumulate, divide, hand the word to the output register; passthrough words go straight to the hand-off
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) state_d = smooth ? S_SUM : S_PUSH;
      end
      S_SUM: begin
        if (left_q == CntW'(1)) state_d = S_START;
      end
      S_START: state_d = S_DIV;
      S_DIV: begin
        if (div_status.done) state_d = S_PUSH;
      end
      S_PUSH: begin
        if (push) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control state, rings and history bookkeeping
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      window_q    <= WINDOW_RESET;
      slot_q      <= '0;
      fill_q      <= '0;
      x_seen_q    <= 1'b0;
      y_seen_q    <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < RingDepth; i++) begin
        x_ring_q[i] <= '0;
        y_ring_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_we_i) window_q <= cfg_wdata_i;

      // Store the delta, fill the other axis on sync, advance the slot
      if (accept && smooth) begin
        if (is_y) begin
          y_ring_q[slot_q] <= delta;
        end else begin
          x_ring_q[slot_q] <= delta;
        end
        if (in_data_i.report_end) begin
          if (is_y && !x_seen_q) x_ring_q[slot_q] <= '0;
          if (!is_y && !y_seen_q) y_ring_q[slot_q] <= '0;
          slot_q   <= (slot_q == IdxW'(RingDepth - 1)) ? '0 : slot_q + 1'b1;
          if (fill_q < CntW'(RingDepth)) fill_q <= fill_q + 1'b1;
          x_seen_q <= 1'b0;
          y_seen_q <= 1'b0;
        end else if (is_y) begin
          y_seen_q <= 1'b1;
        end else begin
          x_seen_q <= 1'b1;
        end
      end

      // Hold the output word until taken
      if (push) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      axis_y_q <= is_y;
      rd_idx_q <= slot_q;
      left_q   <= n_take;
      cnt_q    <= n_take;
      acc_q    <= '0;
      res_q.result_value <= in_data_i.sample_value;
      res_q.was_smoothed <= 1'b0;
    end else if (state_q == S_SUM) begin
      acc_q    <= acc_q + SumW'(rd_data);
      rd_idx_q <= (rd_idx_q == '0) ? IdxW'(RingDepth - 1) : rd_idx_q - 1'b1;
      left_q   <= left_q - 1'b1;
    end else if ((state_q == S_DIV) && div_status.done) begin
      res_q.result_value <= VALUE_W'(div_quot);
      res_q.was_smoothed <= 1'b1;
    end
    if (push) out_q <= res_q;
  end

  // Shared serial divider for the window mean
  tama_div #(
    .SumW (SumW),
    .CntW (CntW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (acc_q),
    .divisor_i  (cnt_q),
    .status_o   (div_status),
    .quotient_o (div_quot)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> bench/two_axis_moving_average_test.sv
`timescale 1ns / 1ps
// Self-checking bench for the two-axis moving average: directed reports, window sweeps, random traffic.
module two_axis_moving_average_test;
  import tama_pkg::*;

  localparam int DEPTH       = RING_DEPTH_DEFAULT;
  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_WAIT  = 40;
  localparam int MAX_GAP     = 30;
  localparam int MAX_REPORTS = 10;
  localparam logic [1:0] CLASS_UNUSED = 2'd3;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  in_word_t            in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  out_word_t           out_data;
  logic                cfg_we = 1'b0;
  logic [WINDOW_W-1:0] cfg_wdata = '0;

  // Idle percentages of both sides
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // Predicted filter state
  logic signed [DELTA_W-1:0] x_ring [DEPTH];
  logic signed [DELTA_W-1:0] y_ring [DEPTH];
  int unsigned               wr_slot;
  int unsigned               fill_level;
  logic                      x_hit;
  logic                      y_hit;
  logic [WINDOW_W-1:0]       window_reg;

  out_word_t filtered_words [$];
  out_word_t head_word;
  int        err_count = 0;
  int        quiet_cycles = 0;

  two_axis_moving_average DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Advance the predicted state by one word and return the word it should produce
  function automatic out_word_t filter_word(in_word_t w);
    out_word_t   res;
    int unsigned win;
    int unsigned n;
    int unsigned idx;
    int          sum;
    res.result_value = w.sample_value;
    res.was_smoothed = 1'b0;
    win = window_reg;
    if (win < 1) win = 1;
    if (win > DEPTH) win = DEPTH;
    if ((w.event_class != CLASS_X && w.event_class != CLASS_Y) || win <= 1) return res;
    if (w.event_class == CLASS_X) begin
      x_ring[wr_slot] = w.sample_value[DELTA_W-1:0];
      x_hit = 1'b1;
    end else begin
      y_ring[wr_slot] = w.sample_value[DELTA_W-1:0];
      y_hit = 1'b1;
    end
    n = (fill_level + 1 > win) ? win : fill_level + 1;
    sum = 0;
    for (int k = 0; k < n; k++) begin
      idx = (wr_slot + DEPTH - k) % DEPTH;
      sum += (w.event_class == CLASS_X) ? x_ring[idx] : y_ring[idx];
    end
    res.result_value = sum / int'(n);
    res.was_smoothed = 1'b1;
    // Close the report: zero the silent axis, advance the slot
    if (w.report_end) begin
      if (!x_hit) x_ring[wr_slot] = '0;
      if (!y_hit) y_ring[wr_slot] = '0;
      wr_slot = (wr_slot + 1) % DEPTH;
      if (fill_level < DEPTH) fill_level++;
      x_hit = 1'b0;
      y_hit = 1'b0;
    end
    return res;
  endfunction

  // Hold a word on the input channel until taken, then record its prediction
  task automatic send_word(logic [1:0] cls, logic [31:0] value, logic sync);
    in_word_t w;
    int       gap;
    w = '0;
    w.event_class  = cls;
    w.sample_value = value;
    w.report_end   = sync;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    filtered_words.push_back(filter_word(w));
  endtask

  // Drop valid and wait until every predicted word has come out
  task automatic drain_words();
    in_valid <= 1'b0;
    while (filtered_words.size() != 0) @(posedge clk);
  endtask

  task automatic set_window(logic [WINDOW_W-1:0] value);
    drain_words();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    window_reg = value;
  endtask

  function automatic logic [31:0] pick_delta();
    int pick;
    pick = $urandom_range(3);
    case (pick)
      0: begin
        return 32'($urandom_range(255)) - 32'd128;
      end
      1: begin
        return $urandom;
      end
      2: begin
        case ($urandom_range(3))
          0: return {16'($urandom_range(16'hFFFF)), 16'h7FFF};
          1: return {16'($urandom_range(16'hFFFF)), 16'h8000};
          2: return {16'($urandom_range(16'hFFFF)), 16'hFFFF};
          default: return {16'($urandom_range(16'hFFFF)), 16'h0000};
        endcase
      end
      default: begin
        return 32'($urandom_range(4000)) - 32'd2000;
      end
    endcase
  endfunction

  // Window 3 after reset: field extremes, both axes, silent axis, passthrough classes
  task automatic test_directed_reports();
    send_word(CLASS_X, 32'h7FFF_FFFF, 1'b0);
    send_word(CLASS_Y, 32'h0000_8000, 1'b1);
    send_word(CLASS_X, 32'h8000_0000, 1'b0);
    send_word(CLASS_Y, 32'h0000_7FFF, 1'b1);
    send_word(CLASS_Y, 32'hFFFF_8001, 1'b1);
    send_word(CLASS_X, 32'h0001_2345, 1'b1);
    send_word(CLASS_OTHER, 32'hDEAD_BEEF, 1'b1);
    send_word(CLASS_UNUSED, 32'h55AA_55AA, 1'b1);
    send_word(CLASS_X, 32'hFFFF_FFFF, 1'b0);
    send_word(CLASS_X, 32'h0000_0001, 1'b1);
    send_word(CLASS_OTHER, 32'h0000_0000, 1'b0);
  endtask

  // Passthrough windows, oversized window and the deepest and shallowest real ones
  task automatic test_window_edges();
    set_window(4'd0);
    send_word(CLASS_X, 32'h1234_8765, 1'b1);
    send_word(CLASS_Y, 32'hFFFF_0000, 1'b1);
    set_window(4'd1);
    send_word(CLASS_X, 32'h0000_0042, 1'b1);
    set_window(4'd15);
    send_word(CLASS_X, 32'h0000_7FFF, 1'b0);
    send_word(CLASS_Y, 32'hFFFF_8000, 1'b1);
    send_word(CLASS_X, 32'h0000_7FFF, 1'b1);
    send_word(CLASS_Y, 32'hFFFF_8000, 1'b1);
    set_window(4'd8);
    send_word(CLASS_X, 32'hFFFF_FFF9, 1'b1);
    send_word(CLASS_Y, 32'h0000_0007, 1'b1);
    set_window(4'd2);
    send_word(CLASS_Y, 32'h0000_0003, 1'b0);
    send_word(CLASS_X, 32'hFFFF_FFFE, 1'b1);
  endtask

  // Random reports, mostly well formed, with some noise and broken reports
  task automatic run_reports(int unsigned count);
    int unsigned sent;
    int          kind;
    sent = 0;
    while (sent < count) begin
      kind = $urandom_range(99);
      if (kind < 30) begin
        send_word(CLASS_X, pick_delta(), 1'b0);
        send_word(CLASS_Y, pick_delta(), 1'b1);
        sent += 2;
      end else if (kind < 50) begin
        send_word(CLASS_Y, pick_delta(), 1'b0);
        send_word(CLASS_X, pick_delta(), 1'b1);
        sent += 2;
      end else if (kind < 62) begin
        send_word(CLASS_X, pick_delta(), 1'b1);
        sent += 1;
      end else if (kind < 74) begin
        send_word(CLASS_Y, pick_delta(), 1'b1);
        sent += 1;
      end else if (kind < 80) begin
        send_word(CLASS_X, pick_delta(), 1'b0);
        send_word(CLASS_X, pick_delta(), 1'b0);
        send_word(CLASS_Y, pick_delta(), 1'b1);
        sent += 3;
      end else if (kind < 88) begin
        send_word(CLASS_OTHER, $urandom, 1'($urandom_range(1)));
        sent += 1;
      end else if (kind < 92) begin
        send_word(CLASS_UNUSED, $urandom, 1'($urandom_range(1)));
        sent += 1;
      end else begin
        send_word(1'($urandom_range(1)) ? CLASS_Y : CLASS_X, pick_delta(), 1'b0);
        sent += 1;
      end
      // Now and then hold off until the block has emptied
      if ($urandom_range(39) == 0) drain_words();
    end
  endtask

  task automatic test_random_phase(int sp, int rp, logic [WINDOW_W-1:0] w0,
                                   logic [WINDOW_W-1:0] w1, logic [WINDOW_W-1:0] w2);
    send_idle_pct = sp;
    recv_idle_pct = rp;
    set_window(w0);
    run_reports(47);
    set_window(w1);
    run_reports(47);
    set_window(w2);
    run_reports(47);
  endtask

  // Randomize receiver backpressure
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Check each output word against the oldest prediction; watch for a hang
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (out_valid && out_ready) begin
        if (filtered_words.size() == 0) begin
          err_count++;
          if (err_count <= 10)
            $display("unexpected word: value %h smoothed %b",
                     out_data.result_value, out_data.was_smoothed);
        end else begin
          head_word = filtered_words.pop_front();
          if (out_data.result_value !== head_word.result_value ||
              out_data.was_smoothed !== head_word.was_smoothed) begin
            err_count++;
            if (err_count <= 10)
              $display("mismatch: expected value %h smoothed %b, got value %h smoothed %b",
                       head_word.result_value, head_word.was_smoothed,
                       out_data.result_value, out_data.was_smoothed);
          end
        end
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    for (int i = 0; i < DEPTH; i++) begin
      x_ring[i] = '0;
      y_ring[i] = '0;
    end
    wr_slot    = 0;
    fill_level = 0;
    x_hit      = 1'b0;
    y_hit      = 1'b0;
    window_reg = WINDOW_RESET;
    send_idle_pct = 28;
    recv_idle_pct = 87;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_reports();
    test_window_edges();
    test_random_phase(28, 87, 4'd8, 4'd2, 4'($urandom_range(3, 7)));
    test_random_phase(87, 28, 4'd15, 4'd4, 4'd1);
    test_random_phase(0, 0, 4'd6, 4'd7, 4'($urandom_range(15)));

    drain_words();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (err_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
